// ===== src/wpn_pkg.sv =====
// Package for the web path normaliser: item types, burst type and character codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package wpn_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int CNT_W = 3;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       path_end;
    logic       path_ok;
  } out_item_t;

  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] items;
    logic [CNT_W-1:0]            count;
  } burst_t;

  typedef struct packed {
    logic       at_start;
    logic [1:0] seg_count;
    logic [7:0] held_one;
    logic [7:0] held_two;
    logic       kept_any;
    logic       rejected;
  } norm_state_t;

  localparam norm_state_t STATE_RESET = '{
    at_start:  1'b1,
    seg_count: 2'd0,
    held_one:  8'h00,
    held_two:  8'h00,
    kept_any:  1'b0,
    rejected:  1'b0
  };

endpackage

// ===== src/web_path_normalizer_top.sv =====
// An input item is registered, then its results are registered and offered.
// Throughput: one input item per cycle if out_ready is high and each yields at most
// one result; an item with k results (k up to 5) stalls the input until all are sent.
// Reset (rst_n low, synchronous): input and result registers empty, path state cleared.
// Top level of the web path normaliser; depends on wpn_pkg, wpn_core and wpn_serial.
`timescale 1ns / 1ps
module web_path_normalizer_top import wpn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic     in_valid_r;
  in_item_t in_item_r;
  burst_t   burst;
  logic     can_load;
  logic     advance;

  assign advance  = in_valid_r && ((burst.count == '0) || can_load);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  wpn_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .burst (burst)
  );

  wpn_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .burst     (burst),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== src/wpn_core.sv =====
// Normalisation step: path state register and the burst of result items for one input item.
// Depends on wpn_pkg.
`timescale 1ns / 1ps
module wpn_core import wpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_item_t item,
  output burst_t   burst
);

  norm_state_t state_r;
  norm_state_t state_nxt;

  always_comb begin
    norm_state_t s;
    burst_t      b;
    logic [7:0]  ch;
    logic        do_close;
    s = state_r;
    b = '0;
    ch = item.path_byte;
    do_close = 1'b0;

    if (!s.rejected) begin
      if (s.at_start) begin
        s.at_start = 1'b0;
        if (ch != SLASH_CHAR) begin
          s.rejected = 1'b1;
        end else begin
          b.items[b.count] = '{out_byte: SLASH_CHAR, byte_valid: 1'b1,
                               path_end: 1'b0, path_ok: 1'b0};
          b.count = b.count + 1'b1;
        end
      end else if (ch == BACKSLASH_CHAR) begin
        s.rejected = 1'b1;
      end else if (ch == SLASH_CHAR) begin
        do_close = 1'b1;
      end else begin
        case (s.seg_count)
          2'd0: begin
            s.held_one = ch;
            s.seg_count = 2'd1;
          end
          2'd1: begin
            s.held_two = ch;
            s.seg_count = 2'd2;
          end
          2'd2: begin
            if (s.kept_any) begin
              b.items[b.count] = '{out_byte: SLASH_CHAR, byte_valid: 1'b1,
                                   path_end: 1'b0, path_ok: 1'b0};
              b.count = b.count + 1'b1;
            end
            s.kept_any = 1'b1;
            b.items[b.count] = '{out_byte: s.held_one, byte_valid: 1'b1,
                                 path_end: 1'b0, path_ok: 1'b0};
            b.count = b.count + 1'b1;
            b.items[b.count] = '{out_byte: s.held_two, byte_valid: 1'b1,
                                 path_end: 1'b0, path_ok: 1'b0};
            b.count = b.count + 1'b1;
            b.items[b.count] = '{out_byte: ch, byte_valid: 1'b1,
                                 path_end: 1'b0, path_ok: 1'b0};
            b.count = b.count + 1'b1;
            s.seg_count = 2'd3;
          end
          default: begin
            b.items[b.count] = '{out_byte: ch, byte_valid: 1'b1,
                                 path_end: 1'b0, path_ok: 1'b0};
            b.count = b.count + 1'b1;
          end
        endcase
      end
    end

    if (item.is_last && !s.rejected) begin
      do_close = 1'b1;
    end

    if (do_close) begin
      if (s.seg_count == 2'd1) begin
        if (s.held_one != DOT_CHAR) begin
          if (s.kept_any) begin
            b.items[b.count] = '{out_byte: SLASH_CHAR, byte_valid: 1'b1,
                                 path_end: 1'b0, path_ok: 1'b0};
            b.count = b.count + 1'b1;
          end
          s.kept_any = 1'b1;
          b.items[b.count] = '{out_byte: s.held_one, byte_valid: 1'b1,
                               path_end: 1'b0, path_ok: 1'b0};
          b.count = b.count + 1'b1;
        end
      end else if (s.seg_count == 2'd2) begin
        if (s.held_one == DOT_CHAR && s.held_two == DOT_CHAR) begin
          s.rejected = 1'b1;
        end else begin
          if (s.kept_any) begin
            b.items[b.count] = '{out_byte: SLASH_CHAR, byte_valid: 1'b1,
                                 path_end: 1'b0, path_ok: 1'b0};
            b.count = b.count + 1'b1;
          end
          s.kept_any = 1'b1;
          b.items[b.count] = '{out_byte: s.held_one, byte_valid: 1'b1,
                               path_end: 1'b0, path_ok: 1'b0};
          b.count = b.count + 1'b1;
          b.items[b.count] = '{out_byte: s.held_two, byte_valid: 1'b1,
                               path_end: 1'b0, path_ok: 1'b0};
          b.count = b.count + 1'b1;
        end
      end
      s.seg_count = 2'd0;
    end

    if (item.is_last) begin
      b.items[b.count] = '{out_byte: 8'h00, byte_valid: 1'b0,
                           path_end: 1'b1, path_ok: !s.rejected};
      b.count = b.count + 1'b1;
      s = STATE_RESET;
    end

    state_nxt = s;
    burst = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/wpn_serial.sv =====
// Result register: holds one burst of result items and hands them out one per cycle while out_ready is high.
// Depends on wpn_pkg.
`timescale 1ns / 1ps
module wpn_serial import wpn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  burst_t    burst,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t [MAX_RESULTS-1:0] items_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [CNT_W-1:0]            rd_r;
  logic [CNT_W-1:0]            rd_nxt;

  assign out_valid = (rd_r != cnt_r);
  assign out_item  = items_r[rd_r];
  assign rd_nxt    = rd_r + 1'b1;
  assign can_load  = !out_valid || (out_ready && (rd_nxt == cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (load && (burst.count != '0)) begin
      cnt_r <= burst.count;
      rd_r  <= '0;
    end else if (out_valid && out_ready) begin
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && (burst.count != '0)) begin
      items_r <= burst.items;
    end
  end

endmodule
